// ----- hw/rtl/cdms_pkg.sv -----
// shared types and constants for the closest display mode selector
`default_nettype none

package cdms_pkg;

  localparam int RATE_BITS       = 10;
  localparam int DEPTH_BITS      = 5;
  localparam int CARE_BITS       = 4;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int COLOR_COST_BITS = 6;
  // three depth distances of up to 31 each
  localparam int COLOR_SUM_BITS  = 7;
  localparam int RATE_COST_BITS  = 32;

  localparam logic [COLOR_COST_BITS-1:0] COLOR_COST_MAX = '1;
  localparam logic [RATE_COST_BITS-1:0]  RATE_COST_MAX  = '1;

  localparam int CARE_RED_BIT   = 0;
  localparam int CARE_GREEN_BIT = 1;
  localparam int CARE_BLUE_BIT  = 2;
  localparam int CARE_RATE_BIT  = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WANT_WIDTH  = 3'd0,
    CFG_WANT_HEIGHT = 3'd1,
    CFG_WANT_RATE   = 3'd2,
    CFG_WANT_RED    = 3'd3,
    CFG_WANT_GREEN  = 3'd4,
    CFG_WANT_BLUE   = 3'd5,
    CFG_CARE_MASK   = 3'd6
  } cfg_idx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cdms_mode_if.sv -----
// candidate mode channel: valid, ready and one display mode
`default_nettype none

interface cdms_mode_if #(
  parameter int DIM_BITS = 14
);
  logic                            valid;
  logic                            ready;
  logic [DIM_BITS-1:0]             mode_width;
  logic [DIM_BITS-1:0]             mode_height;
  logic [cdms_pkg::RATE_BITS-1:0]  mode_rate;
  logic [cdms_pkg::DEPTH_BITS-1:0] mode_red;
  logic [cdms_pkg::DEPTH_BITS-1:0] mode_green;
  logic [cdms_pkg::DEPTH_BITS-1:0] mode_blue;
  logic                            last_mode;

  modport source (
    output valid, mode_width, mode_height, mode_rate, mode_red, mode_green, mode_blue,
           last_mode,
    input  ready
  );

  modport sink (
    input  valid, mode_width, mode_height, mode_rate, mode_red, mode_green, mode_blue,
           last_mode,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/cdms_best_if.sv -----
// result channel: valid, ready and the chosen display mode
`default_nettype none

interface cdms_best_if #(
  parameter int DIM_BITS = 14
);
  logic                            valid;
  logic                            ready;
  logic [DIM_BITS-1:0]             best_width;
  logic [DIM_BITS-1:0]             best_height;
  logic [cdms_pkg::RATE_BITS-1:0]  best_rate;
  logic [cdms_pkg::DEPTH_BITS-1:0] best_red;
  logic [cdms_pkg::DEPTH_BITS-1:0] best_green;
  logic [cdms_pkg::DEPTH_BITS-1:0] best_blue;

  modport source (
    output valid, best_width, best_height, best_rate, best_red, best_green, best_blue,
    input  ready
  );

  modport sink (
    input  valid, best_width, best_height, best_rate, best_red, best_green, best_blue,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/closest_display_mode_select.sv -----
// Closest display mode selector. Candidate modes arrive one per transfer on in_ch and
// are ranked against the wanted mode held in the cfg registers: first by color depth
// distance over the channels enabled in care_mask, then by squared size distance, then
// by refresh distance (or by highest rate when rate is not cared about); the earlier
// mode wins a full tie. The transfer marked last_mode is ranked too, then the chosen
// mode goes out as one transfer on out_ch and the running best is cleared for the next
// list. A candidate is taken every cycle: an input register, a cost stage (two 14x14
// squares and the depth distances) and a compare stage against the registered best,
// which writes the result register. The only stall is a last candidate reaching the
// compare stage while the previous result is still untaken; other candidates keep
// flowing behind an unread result. Write cfg only while idle.
`default_nettype none

module closest_display_mode_select #(
  parameter  int DIM_BITS = 14,
  localparam int CFG_W    = (DIM_BITS > cdms_pkg::RATE_BITS) ? DIM_BITS : cdms_pkg::RATE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [cdms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]                    cfg_data,
  cdms_mode_if.sink                                in_ch,
  cdms_best_if.source                              out_ch
);
  import cdms_pkg::*;

  localparam int SQ_W   = 2 * DIM_BITS;
  localparam int SIZE_W = 2 * DIM_BITS + 2;

  // configuration registers
  logic [DIM_BITS-1:0]   want_width_r;
  logic [DIM_BITS-1:0]   want_height_r;
  logic [RATE_BITS-1:0]  want_rate_r;
  logic [DEPTH_BITS-1:0] want_red_r;
  logic [DEPTH_BITS-1:0] want_green_r;
  logic [DEPTH_BITS-1:0] want_blue_r;
  logic [CARE_BITS-1:0]  care_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_width_r  <= '0;
      want_height_r <= '0;
      want_rate_r   <= RATE_BITS'(60);
      want_red_r    <= DEPTH_BITS'(8);
      want_green_r  <= DEPTH_BITS'(8);
      want_blue_r   <= DEPTH_BITS'(8);
      care_mask_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WANT_WIDTH:  want_width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_WANT_HEIGHT: want_height_r <= cfg_data[DIM_BITS-1:0];
        CFG_WANT_RATE:   want_rate_r   <= cfg_data[RATE_BITS-1:0];
        CFG_WANT_RED:    want_red_r    <= cfg_data[DEPTH_BITS-1:0];
        CFG_WANT_GREEN:  want_green_r  <= cfg_data[DEPTH_BITS-1:0];
        CFG_WANT_BLUE:   want_blue_r   <= cfg_data[DEPTH_BITS-1:0];
        CFG_CARE_MASK:   care_mask_r   <= cfg_data[CARE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic s2_valid_r;
  logic s2_last_r;
  logic out_valid_r;
  logic blocked;
  logic s1_load;
  logic s2_load;
  logic cmp_fire;

  // a last candidate may not enter the compare stage while a result is still waiting
  assign blocked  = s2_valid_r && s2_last_r && out_valid_r && !out_ch.ready;
  assign s1_load  = !s1_valid_r || !blocked;
  assign s2_load  = !blocked;
  assign cmp_fire = s2_valid_r && !blocked;

  assign in_ch.ready = s1_load;

  // input register
  logic [DIM_BITS-1:0]   s1_width_r;
  logic [DIM_BITS-1:0]   s1_height_r;
  logic [RATE_BITS-1:0]  s1_rate_r;
  logic [DEPTH_BITS-1:0] s1_red_r;
  logic [DEPTH_BITS-1:0] s1_green_r;
  logic [DEPTH_BITS-1:0] s1_blue_r;
  logic                  s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_ch.valid) begin
      s1_width_r  <= in_ch.mode_width;
      s1_height_r <= in_ch.mode_height;
      s1_rate_r   <= in_ch.mode_rate;
      s1_red_r    <= in_ch.mode_red;
      s1_green_r  <= in_ch.mode_green;
      s1_blue_r   <= in_ch.mode_blue;
      s1_last_r   <= in_ch.last_mode;
    end
  end

  // cost stage
  logic [DIM_BITS-1:0]        dx;
  logic [DIM_BITS-1:0]        dy;
  logic [SQ_W-1:0]            sq_x;
  logic [SQ_W-1:0]            sq_y;
  logic [SIZE_W-1:0]          size_cost;
  logic [DEPTH_BITS-1:0]      d_red;
  logic [DEPTH_BITS-1:0]      d_green;
  logic [DEPTH_BITS-1:0]      d_blue;
  logic [COLOR_SUM_BITS-1:0]  color_sum;
  logic [COLOR_COST_BITS-1:0] color_cost;
  logic [RATE_BITS-1:0]       d_rate;
  logic [RATE_COST_BITS-1:0]  rate_cost;

  always_comb begin
    dx      = (s1_width_r >= want_width_r) ? s1_width_r - want_width_r
                                           : want_width_r - s1_width_r;
    dy      = (s1_height_r >= want_height_r) ? s1_height_r - want_height_r
                                             : want_height_r - s1_height_r;
    sq_x      = SQ_W'(dx) * SQ_W'(dx);
    sq_y      = SQ_W'(dy) * SQ_W'(dy);
    size_cost = SIZE_W'(sq_x) + SIZE_W'(sq_y);

    d_red   = (s1_red_r >= want_red_r) ? s1_red_r - want_red_r : want_red_r - s1_red_r;
    d_green = (s1_green_r >= want_green_r) ? s1_green_r - want_green_r
                                           : want_green_r - s1_green_r;
    d_blue  = (s1_blue_r >= want_blue_r) ? s1_blue_r - want_blue_r
                                         : want_blue_r - s1_blue_r;
    color_sum = (care_mask_r[CARE_RED_BIT]   ? COLOR_SUM_BITS'(d_red)   : '0)
              + (care_mask_r[CARE_GREEN_BIT] ? COLOR_SUM_BITS'(d_green) : '0)
              + (care_mask_r[CARE_BLUE_BIT]  ? COLOR_SUM_BITS'(d_blue)  : '0);
    // saturate at the all-ones cost
    color_cost = (color_sum > COLOR_SUM_BITS'(COLOR_COST_MAX))
               ? COLOR_COST_MAX : color_sum[COLOR_COST_BITS-1:0];

    d_rate    = (s1_rate_r >= want_rate_r) ? s1_rate_r - want_rate_r
                                           : want_rate_r - s1_rate_r;
    // rate don't-care prefers the highest rate
    rate_cost = care_mask_r[CARE_RATE_BIT] ? RATE_COST_BITS'(d_rate)
                                           : RATE_COST_MAX - RATE_COST_BITS'(s1_rate_r);
  end

  logic [DIM_BITS-1:0]        s2_width_r;
  logic [DIM_BITS-1:0]        s2_height_r;
  logic [RATE_BITS-1:0]       s2_rate_r;
  logic [DEPTH_BITS-1:0]      s2_red_r;
  logic [DEPTH_BITS-1:0]      s2_green_r;
  logic [DEPTH_BITS-1:0]      s2_blue_r;
  logic [COLOR_COST_BITS-1:0] s2_color_cost_r;
  logic [SIZE_W-1:0]          s2_size_cost_r;
  logic [RATE_COST_BITS-1:0]  s2_rate_cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_width_r      <= s1_width_r;
      s2_height_r     <= s1_height_r;
      s2_rate_r       <= s1_rate_r;
      s2_red_r        <= s1_red_r;
      s2_green_r      <= s1_green_r;
      s2_blue_r       <= s1_blue_r;
      s2_last_r       <= s1_last_r;
      s2_color_cost_r <= color_cost;
      s2_size_cost_r  <= size_cost;
      s2_rate_cost_r  <= rate_cost;
    end
  end

  // compare stage against the running best
  logic                       have_best_r;
  logic [COLOR_COST_BITS-1:0] least_color_cost_r;
  logic [SIZE_W-1:0]          least_size_cost_r;
  logic [RATE_COST_BITS-1:0]  least_rate_cost_r;
  logic [DIM_BITS-1:0]        held_width_r;
  logic [DIM_BITS-1:0]        held_height_r;
  logic [RATE_BITS-1:0]       held_rate_r;
  logic [DEPTH_BITS-1:0]      held_red_r;
  logic [DEPTH_BITS-1:0]      held_green_r;
  logic [DEPTH_BITS-1:0]      held_blue_r;
  logic                       better;

  always_comb begin
    better = !have_best_r
          || (s2_color_cost_r < least_color_cost_r)
          || (s2_color_cost_r == least_color_cost_r
              && s2_size_cost_r < least_size_cost_r)
          || (s2_color_cost_r == least_color_cost_r
              && s2_size_cost_r == least_size_cost_r
              && s2_rate_cost_r < least_rate_cost_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (cmp_fire) begin
      // the last candidate of a list leaves nothing behind
      have_best_r <= !s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_fire && better) begin
      least_color_cost_r <= s2_color_cost_r;
      least_size_cost_r  <= s2_size_cost_r;
      least_rate_cost_r  <= s2_rate_cost_r;
      held_width_r       <= s2_width_r;
      held_height_r      <= s2_height_r;
      held_rate_r        <= s2_rate_r;
      held_red_r         <= s2_red_r;
      held_green_r       <= s2_green_r;
      held_blue_r        <= s2_blue_r;
    end
  end

  // result register
  logic [DIM_BITS-1:0]   out_width_r;
  logic [DIM_BITS-1:0]   out_height_r;
  logic [RATE_BITS-1:0]  out_rate_r;
  logic [DEPTH_BITS-1:0] out_red_r;
  logic [DEPTH_BITS-1:0] out_green_r;
  logic [DEPTH_BITS-1:0] out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmp_fire && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_fire && s2_last_r) begin
      out_width_r  <= better ? s2_width_r  : held_width_r;
      out_height_r <= better ? s2_height_r : held_height_r;
      out_rate_r   <= better ? s2_rate_r   : held_rate_r;
      out_red_r    <= better ? s2_red_r    : held_red_r;
      out_green_r  <= better ? s2_green_r  : held_green_r;
      out_blue_r   <= better ? s2_blue_r   : held_blue_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_width  = out_width_r;
  assign out_ch.best_height = out_height_r;
  assign out_ch.best_rate   = out_rate_r;
  assign out_ch.best_red    = out_red_r;
  assign out_ch.best_green  = out_green_r;
  assign out_ch.best_blue   = out_blue_r;

  // a waiting result is never overwritten by the next list's result
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(cmp_fire && s2_last_r))
    else $error("result register overwritten while a result waits");

  // a stalled last candidate stays in the compare stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    blocked |=> (s2_valid_r && s2_last_r))
    else $error("stalled last candidate lost from compare stage");

  // the running best clears after a list ends and is set by any other candidate
  a_best_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_fire && s2_last_r) |=> (!have_best_r && out_valid_r))
    else $error("running best not cleared or result missing after last candidate");

  a_best_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_fire && !s2_last_r) |=> have_best_r)
    else $error("running best not held after a candidate");

endmodule

`default_nettype wire
